// ===== design/rfc_pkg.sv =====
// ----------------------------------------------------------------------------
// rfc_pkg: record framer shared definitions
// Item, result and job types, status codes and framing constants used by the
// front end, the back end and the top level of the CRC-16 record framer.
// ----------------------------------------------------------------------------
package rfc_pkg;

  // Status code carried with every result byte
  typedef enum logic [1:0] {
    ST_FRAME    = 2'd0,
    ST_OFF      = 2'd1,
    ST_BIG      = 2'd2,
    ST_MISMATCH = 2'd3
  } status_t;

  // One input item
  typedef struct packed {
    logic [7:0]  record_type;
    logic [15:0] payload_length;
    logic [7:0]  data_byte;
    logic        has_data;
    logic        is_last;
  } in_item_t;

  // One result item
  typedef struct packed {
    logic [7:0] out_byte;
    status_t    status;
    logic       frame_end;
    logic       last_result;
  } out_item_t;

  // Classified work handed from the front end to the back end
  typedef struct packed {
    logic        reject;
    status_t     rej_status;
    logic        header;
    logic [7:0]  record_type;
    logic [15:0] payload_length;
    logic [31:0] seq;
    logic        has_data;
    logic [7:0]  data_byte;
    logic        is_last;
    logic        mismatch;
  } job_t;

  // Framing constants
  localparam logic [7:0]  SYNC_A      = 8'hA5;
  localparam logic [7:0]  SYNC_B      = 8'h5A;
  localparam logic [7:0]  VERSION     = 8'h01;
  localparam logic [15:0] CRC_INIT    = 16'hFFFF;
  localparam logic [15:0] CRC_POLY    = 16'h1021;
  localparam logic [15:0] COUNT_MAX   = 16'hFFFF;

  // Sizing defaults
  localparam int unsigned PAYLOAD_CAPACITY_DEFAULT = 256;
  localparam int unsigned JOB_DEPTH                = 2;
  localparam int unsigned OUT_DEPTH                = 2;

endpackage

// ===== design/rfc_fifo.sv =====
// ----------------------------------------------------------------------------
// rfc_fifo: small register queue
// Flip-flop queue of any packed type; the head entry is shown while not empty.
// ----------------------------------------------------------------------------
module rfc_fifo #(
  parameter type         data_t = logic [7:0],
  parameter int unsigned DEPTH  = 2
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  data_t wdata,
  output logic  full,
  input  logic  pop,
  output data_t rdata,
  output logic  empty
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  data_t           store [DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic            do_push;
  logic            do_pop;

  // Flag and handshake qualification
  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = store[rd_ptr];

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Write storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wr_ptr] <= wdata;
    end
  end

endmodule

// ===== design/rfc_front.sv =====
// ----------------------------------------------------------------------------
// rfc_front: record framer front end
// Accepts items, tracks record state, length count and sequence number, and
// turns each item into one job for the back end (or none for an empty item).
// ----------------------------------------------------------------------------
module rfc_front #(
  parameter int unsigned PAYLOAD_CAPACITY = rfc_pkg::PAYLOAD_CAPACITY_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_valid,
  input  logic             cfg_data,
  input  logic             accept,
  input  rfc_pkg::in_item_t item,
  output logic             job_push,
  output rfc_pkg::job_t    job
);

  logic        capture_enable;
  logic        capture_enable_next;
  logic        in_record;
  logic        in_record_next;
  logic [31:0] sequence_count;
  logic [31:0] sequence_count_next;
  logic [15:0] bytes_seen;
  logic [15:0] bytes_seen_next;
  logic [15:0] declared_length;
  logic [15:0] declared_length_next;

  logic        open;
  logic [15:0] bytes_base;
  logic [15:0] decl_base;
  logic [15:0] bytes_after;
  logic        oversize;

  assign oversize = ({1'b0, item.payload_length} > 17'(PAYLOAD_CAPACITY));

  // Classify the item and compute next record state
  always_comb begin
    capture_enable_next  = capture_enable;
    in_record_next       = in_record;
    sequence_count_next  = sequence_count;
    bytes_seen_next      = bytes_seen;
    declared_length_next = declared_length;
    open                 = in_record;
    bytes_base           = bytes_seen;
    decl_base            = declared_length;
    bytes_after          = bytes_seen;
    job                  = '0;
    job_push             = 1'b0;

    if (accept) begin
      // Start of a record: reject or open
      if (!in_record) begin
        if (!capture_enable) begin
          job.reject     = 1'b1;
          job.rej_status = rfc_pkg::ST_OFF;
        end else if (oversize) begin
          job.reject     = 1'b1;
          job.rej_status = rfc_pkg::ST_BIG;
        end else begin
          job.header          = 1'b1;
          job.record_type     = item.record_type;
          job.payload_length  = item.payload_length;
          job.seq             = sequence_count;
          sequence_count_next = sequence_count + 32'd1;
          open                = 1'b1;
          bytes_base          = '0;
          decl_base           = item.payload_length;
          in_record_next      = 1'b1;
        end
      end

      // Payload and end of record
      if (open) begin
        if (item.has_data && (bytes_base != rfc_pkg::COUNT_MAX)) begin
          bytes_after = bytes_base + 16'd1;
        end else begin
          bytes_after = bytes_base;
        end
        bytes_seen_next      = bytes_after;
        declared_length_next = decl_base;
        job.has_data         = item.has_data;
        job.data_byte        = item.data_byte;
        job.is_last          = item.is_last;
        job.mismatch         = (bytes_after != decl_base);
        if (item.is_last) begin
          in_record_next = 1'b0;
        end
      end

      job_push = job.reject | job.header | job.has_data | job.is_last;
    end

    // Register write; enabling from off restarts the sequence
    if (cfg_valid) begin
      if (cfg_data && !capture_enable) begin
        sequence_count_next = '0;
      end
      capture_enable_next = cfg_data;
    end
  end

  // Hold record state
  always_ff @(posedge clk) begin
    if (rst) begin
      capture_enable  <= 1'b0;
      in_record       <= 1'b0;
      sequence_count  <= '0;
      bytes_seen      <= '0;
      declared_length <= '0;
    end else begin
      capture_enable  <= capture_enable_next;
      in_record       <= in_record_next;
      sequence_count  <= sequence_count_next;
      bytes_seen      <= bytes_seen_next;
      declared_length <= declared_length_next;
    end
  end

endmodule

// ===== design/rfc_back.sv =====
// ----------------------------------------------------------------------------
// rfc_back: record framer back end
// Steps through job bytes, one per cycle while the output queue has room:
// header, payload byte, CRC trailer or reject marker; keeps a running CRC-16.
// ----------------------------------------------------------------------------
module rfc_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               job_empty,
  input  rfc_pkg::job_t      job,
  output logic               job_pop,
  input  logic               out_full,
  output logic               out_push,
  output rfc_pkg::out_item_t result
);

  // Byte positions within a job
  localparam logic [3:0] POS_SYNC_A  = 4'd0;
  localparam logic [3:0] POS_SYNC_B  = 4'd1;
  localparam logic [3:0] POS_VERSION = 4'd2;
  localparam logic [3:0] POS_TYPE    = 4'd3;
  localparam logic [3:0] POS_LEN_LO  = 4'd4;
  localparam logic [3:0] POS_LEN_HI  = 4'd5;
  localparam logic [3:0] POS_SEQ0    = 4'd6;
  localparam logic [3:0] POS_SEQ1    = 4'd7;
  localparam logic [3:0] POS_SEQ2    = 4'd8;
  localparam logic [3:0] POS_SEQ3    = 4'd9;
  localparam logic [3:0] POS_DATA    = 4'd10;
  localparam logic [3:0] POS_CRC_LO  = 4'd11;
  localparam logic [3:0] POS_CRC_HI  = 4'd12;
  localparam logic [3:0] POS_REJECT  = 4'd13;

  // One byte into CRC-16/CCITT, MSB first
  function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ rfc_pkg::CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

  rfc_pkg::job_t cur;
  logic          busy;
  logic [3:0]    pos;
  logic [15:0]   crc;

  logic [3:0]    final_pos;
  logic [3:0]    next_pos;
  logic [3:0]    start_pos;
  logic          emit;
  logic          done;
  logic [7:0]    byte_sel;
  rfc_pkg::status_t crc_status;

  // Sequence the current job
  always_comb begin
    if (cur.reject) begin
      final_pos = POS_REJECT;
    end else if (cur.is_last) begin
      final_pos = POS_CRC_HI;
    end else if (cur.has_data) begin
      final_pos = POS_DATA;
    end else begin
      final_pos = POS_SEQ3;
    end

    if (pos == POS_SEQ3) begin
      next_pos = cur.has_data ? POS_DATA : POS_CRC_LO;
    end else begin
      next_pos = pos + 4'd1;
    end

    if (job.reject) begin
      start_pos = POS_REJECT;
    end else if (job.header) begin
      start_pos = POS_SYNC_A;
    end else if (job.has_data) begin
      start_pos = POS_DATA;
    end else begin
      start_pos = POS_CRC_LO;
    end
  end

  assign emit     = busy && !out_full;
  assign done     = emit && (pos == final_pos);
  assign job_pop  = !job_empty && (!busy || done);
  assign out_push = emit;

  // Select the output byte
  always_comb begin
    case (pos)
      POS_SYNC_A:  byte_sel = rfc_pkg::SYNC_A;
      POS_SYNC_B:  byte_sel = rfc_pkg::SYNC_B;
      POS_VERSION: byte_sel = rfc_pkg::VERSION;
      POS_TYPE:    byte_sel = cur.record_type;
      POS_LEN_LO:  byte_sel = cur.payload_length[7:0];
      POS_LEN_HI:  byte_sel = cur.payload_length[15:8];
      POS_SEQ0:    byte_sel = cur.seq[7:0];
      POS_SEQ1:    byte_sel = cur.seq[15:8];
      POS_SEQ2:    byte_sel = cur.seq[23:16];
      POS_SEQ3:    byte_sel = cur.seq[31:24];
      POS_DATA:    byte_sel = cur.data_byte;
      POS_CRC_LO:  byte_sel = crc[7:0];
      POS_CRC_HI:  byte_sel = crc[15:8];
      default:     byte_sel = 8'h00;
    endcase
  end

  // Build the result
  always_comb begin
    crc_status         = cur.mismatch ? rfc_pkg::ST_MISMATCH : rfc_pkg::ST_FRAME;
    result.out_byte    = byte_sel;
    result.frame_end   = (pos == POS_CRC_HI);
    result.last_result = (pos == final_pos);
    if (pos == POS_REJECT) begin
      result.status = cur.rej_status;
    end else if ((pos == POS_CRC_LO) || (pos == POS_CRC_HI)) begin
      result.status = crc_status;
    end else begin
      result.status = rfc_pkg::ST_FRAME;
    end
  end

  // Advance sequencer and running CRC
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pos  <= POS_SYNC_A;
      crc  <= rfc_pkg::CRC_INIT;
    end else begin
      if (job_pop) begin
        busy <= 1'b1;
        pos  <= start_pos;
      end else if (done) begin
        busy <= 1'b0;
      end else if (emit) begin
        pos <= next_pos;
      end
      if (emit) begin
        if (pos == POS_SYNC_A) begin
          crc <= rfc_pkg::CRC_INIT;
        end else if ((pos >= POS_VERSION) && (pos <= POS_DATA)) begin
          crc <= crc_feed(crc, byte_sel);
        end
      end
    end
  end

  // Hold the job being worked on
  always_ff @(posedge clk) begin
    if (job_pop) begin
      cur <= job;
    end
  end

endmodule

// ===== design/record_framer_crc16_top.sv =====
// ----------------------------------------------------------------------------
// record_framer_crc16_top: CRC-16 record framer
// The first result of an item passes the job queue, the back-end job register
// and the result queue. Throughput: one byte per cycle while the result queue
// has room, set by the back-end sequencer; header and CRC bytes wrap a record.
// Reset (rst, synchronous): capture off, no record open, sequence 0, queues
// empty; the configuration port is always ready.
// ----------------------------------------------------------------------------
module record_framer_crc16_top #(
  parameter int unsigned PAYLOAD_CAPACITY = rfc_pkg::PAYLOAD_CAPACITY_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_data,
  input  logic               push,
  output logic               full,
  input  rfc_pkg::in_item_t  item,
  output logic               empty,
  input  logic               pop,
  output rfc_pkg::out_item_t result
);

  logic               accept;
  logic               job_push;
  rfc_pkg::job_t      job_in;
  logic               job_pop;
  logic               job_empty;
  rfc_pkg::job_t      job_out;
  logic               out_push;
  logic               out_full;
  rfc_pkg::out_item_t out_item;

  assign cfg_ready = 1'b1;
  assign accept    = push && !full;

  // Classify incoming items
  rfc_front #(
    .PAYLOAD_CAPACITY(PAYLOAD_CAPACITY)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_data (cfg_data),
    .accept   (accept),
    .item     (item),
    .job_push (job_push),
    .job      (job_in)
  );

  // Decouple front and back
  rfc_fifo #(
    .data_t(rfc_pkg::job_t),
    .DEPTH (rfc_pkg::JOB_DEPTH)
  ) u_job_q (
    .clk  (clk),
    .rst  (rst),
    .push (job_push),
    .wdata(job_in),
    .full (full),
    .pop  (job_pop),
    .rdata(job_out),
    .empty(job_empty)
  );

  // Emit framed bytes
  rfc_back u_back (
    .clk      (clk),
    .rst      (rst),
    .job_empty(job_empty),
    .job      (job_out),
    .job_pop  (job_pop),
    .out_full (out_full),
    .out_push (out_push),
    .result   (out_item)
  );

  // Hold results until transferred
  rfc_fifo #(
    .data_t(rfc_pkg::out_item_t),
    .DEPTH (rfc_pkg::OUT_DEPTH)
  ) u_out_q (
    .clk  (clk),
    .rst  (rst),
    .push (out_push),
    .wdata(out_item),
    .full (out_full),
    .pop  (pop),
    .rdata(result),
    .empty(empty)
  );

endmodule
